/* rtl/dit_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dit_pkg
// Types, register map codes and timer helpers for the dual interval timer.
// ----------------------------------------------------------------------------
package dit_pkg;

  localparam int unsigned CountWidth = 16;
  localparam int unsigned ByteWidth  = 8;
  localparam int unsigned AddrWidth  = 4;
  localparam int unsigned FlagWidth  = 5;
  localparam int unsigned StoreDepth = 5;
  localparam int unsigned CfgIdxWidth = 1;

  typedef enum logic [1:0] {
    CmdTick  = 2'd0,
    CmdRead  = 2'd1,
    CmdWrite = 2'd2,
    CmdNone  = 2'd3
  } cmd_e;

  typedef enum logic [AddrWidth-1:0] {
    RegPra  = 4'd0,
    RegPrb  = 4'd1,
    RegDdra = 4'd2,
    RegDdrb = 4'd3,
    RegTalo = 4'd4,
    RegTahi = 4'd5,
    RegTblo = 4'd6,
    RegTbhi = 4'd7,
    RegSt0  = 4'd8,
    RegSt1  = 4'd9,
    RegSt2  = 4'd10,
    RegSt3  = 4'd11,
    RegSt4  = 4'd12,
    RegIcr  = 4'd13,
    RegCra  = 4'd14,
    RegCrb  = 4'd15
  } reg_addr_e;

  typedef enum logic [1:0] {
    StrobeNone = 2'd0,
    StrobeRow  = 2'd1,
    StrobeCol  = 2'd2,
    StrobeRsvd = 2'd3
  } strobe_e;

  typedef enum logic [CfgIdxWidth-1:0] {
    CfgUnitIsKeyboard = 1'b0,
    CfgTimerAEnable   = 1'b1
  } cfg_idx_e;

  localparam logic [FlagWidth-1:0] FlagMask = 5'h1f;
  localparam logic [FlagWidth-1:0] FlagA    = 5'h01;
  localparam logic [FlagWidth-1:0] FlagB    = 5'h02;
  localparam logic [AddrWidth-1:0] AddrMask = 4'hf;

  localparam int unsigned CtlRunBit     = 0;
  localparam int unsigned CtlOneShotBit = 3;
  localparam int unsigned CtlLoadBit    = 4;
  localparam int unsigned IcrSetClrBit  = 7;

  typedef struct packed {
    logic [1:0]           cmd;
    logic [AddrWidth-1:0] reg_addr;
    logic [ByteWidth-1:0] write_data;
    logic [ByteWidth-1:0] port_a_in;
    logic [ByteWidth-1:0] port_b_in;
  } item_t;

  typedef struct packed {
    logic [ByteWidth-1:0] read_data;
    logic                 irq;
    logic [1:0]           kbd_strobe;
    logic [ByteWidth-1:0] kbd_value;
  } result_t;

  typedef struct packed {
    logic [CountWidth-1:0] count;
    logic [CountWidth-1:0] latch;
    logic                  running;
    logic                  reload;
  } timer_t;

  typedef struct packed {
    timer_t tmr;
    logic   fired;
  } tick_res_t;

  function automatic tick_res_t timer_tick(timer_t t);
    tick_res_t             r;
    logic [CountWidth-1:0] dec;
    r       = '{tmr: t, fired: 1'b0};
    dec     = t.count - CountWidth'(1);
    if (t.running) begin
      if (t.count == '0 || dec == '0) begin
        r.fired = 1'b1;
        if (t.reload) begin
          r.tmr.count = t.latch;
        end else begin
          r.tmr.count   = (t.count == '0) ? t.count : dec;
          r.tmr.running = 1'b0;
        end
      end else begin
        r.tmr.count = dec;
      end
    end
    return r;
  endfunction

  function automatic timer_t timer_ctl(timer_t t, logic [ByteWidth-1:0] v);
    timer_t r;
    r = t;
    if (v[CtlLoadBit]) begin
      r.count = t.latch;
    end
    r.reload  = ~v[CtlOneShotBit];
    r.running = v[CtlRunBit];
    return r;
  endfunction

endpackage

/* rtl/dit_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dit_if
// Valid/ready channels of the dual interval timer: items, results and
// configuration writes.
// ----------------------------------------------------------------------------
interface dit_in_if
  import dit_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [1:0]           cmd;
  logic [AddrWidth-1:0] reg_addr;
  logic [ByteWidth-1:0] write_data;
  logic [ByteWidth-1:0] port_a_in;
  logic [ByteWidth-1:0] port_b_in;

  modport source (output valid, cmd, reg_addr, write_data, port_a_in, port_b_in,
                  input ready);
  modport sink   (input valid, cmd, reg_addr, write_data, port_a_in, port_b_in,
                  output ready);
endinterface

interface dit_out_if
  import dit_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [ByteWidth-1:0] read_data;
  logic                 irq;
  logic [1:0]           kbd_strobe;
  logic [ByteWidth-1:0] kbd_value;

  modport source (output valid, read_data, irq, kbd_strobe, kbd_value, input ready);
  modport sink   (input valid, read_data, irq, kbd_strobe, kbd_value, output ready);
endinterface

interface dit_cfg_if
  import dit_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [CfgIdxWidth-1:0] index;
  logic                   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/dual_interval_timer_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_interval_timer_regs
// Two 16-bit down-counting timers behind a 16-byte register map, with an
// interrupt control register, plain storage bytes and keyboard port hooks.
// ----------------------------------------------------------------------------
// One transaction per cycle while the result side keeps up: each
// accepted tick, read or write lands in an input register, is applied to
// the timer and register state once the output register is free or being
// drained, and its result is held in that output register. Configuration
// writes are accepted every cycle and take effect at once; issue them only
// while no transaction is in flight.
module dual_interval_timer_regs
  import dit_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  dit_cfg_if.sink   cfg_i,
  dit_in_if.sink    in_i,
  dit_out_if.source out_o
);

  logic                 unit_kbd_q;
  logic                 ta_en_q;

  logic                 in_valid_q;
  item_t                in_q;
  logic                 out_valid_q;
  result_t              out_q;
  result_t              out_d;

  timer_t               ta_q, ta_d, tb_q, tb_d;
  logic [FlagWidth-1:0] flags_q, flags_d;
  logic                 irq_q, irq_d;
  logic [ByteWidth-1:0] store_q [StoreDepth];
  logic [ByteWidth-1:0] store_d [StoreDepth];

  logic                 advance;
  tick_res_t            ta_tick, tb_tick;
  logic [2:0]           st_idx;

  assign advance     = in_valid_q & (~out_valid_q | out_o.ready);
  assign in_i.ready  = ~in_valid_q | advance;
  assign cfg_i.ready = 1'b1;

  assign out_o.valid      = out_valid_q;
  assign out_o.read_data  = out_q.read_data;
  assign out_o.irq        = out_q.irq;
  assign out_o.kbd_strobe = out_q.kbd_strobe;
  assign out_o.kbd_value  = out_q.kbd_value;

  assign st_idx = 3'(in_q.reg_addr - RegSt0);

  always_comb begin
    ta_d    = ta_q;
    tb_d    = tb_q;
    flags_d = flags_q;
    irq_d   = irq_q;
    store_d = store_q;
    out_d   = '0;
    ta_tick = timer_tick(ta_q);
    tb_tick = timer_tick(tb_q);

    case (cmd_e'(in_q.cmd))
      CmdTick: begin
        if (ta_en_q) begin
          ta_d = ta_tick.tmr;
          if (ta_tick.fired) begin
            flags_d = flags_d | FlagA;
            irq_d   = 1'b1;
          end
        end
        tb_d = tb_tick.tmr;
        if (tb_tick.fired) begin
          flags_d = flags_d | FlagB;
          irq_d   = 1'b1;
        end
      end
      CmdRead: begin
        case (reg_addr_e'(in_q.reg_addr & AddrMask))
          RegPra:  out_d.read_data = unit_kbd_q ? in_q.port_a_in : '0;
          RegPrb:  out_d.read_data = unit_kbd_q ? in_q.port_b_in : '0;
          RegTalo: out_d.read_data = ta_q.latch[ByteWidth-1:0];
          RegTahi: out_d.read_data = ta_q.latch[CountWidth-1:ByteWidth];
          RegTblo: out_d.read_data = tb_q.latch[ByteWidth-1:0];
          RegTbhi: out_d.read_data = tb_q.latch[CountWidth-1:ByteWidth];
          RegSt0, RegSt1, RegSt2, RegSt3, RegSt4: out_d.read_data = store_q[st_idx];
          RegIcr: begin
            out_d.read_data = ByteWidth'(flags_q & FlagMask);
            flags_d         = '0;
            irq_d           = 1'b0;
          end
          default: out_d.read_data = '0;
        endcase
      end
      CmdWrite: begin
        case (reg_addr_e'(in_q.reg_addr & AddrMask))
          RegDdra: begin
            if (unit_kbd_q) begin
              out_d.kbd_strobe = StrobeRow;
              out_d.kbd_value  = in_q.write_data;
            end
          end
          RegDdrb: begin
            if (unit_kbd_q) begin
              out_d.kbd_strobe = StrobeCol;
              out_d.kbd_value  = in_q.write_data;
            end
          end
          RegTalo: ta_d.latch[ByteWidth-1:0]          = in_q.write_data;
          RegTahi: ta_d.latch[CountWidth-1:ByteWidth] = in_q.write_data;
          RegTblo: tb_d.latch[ByteWidth-1:0]          = in_q.write_data;
          RegTbhi: tb_d.latch[CountWidth-1:ByteWidth] = in_q.write_data;
          RegSt0, RegSt1, RegSt2, RegSt3, RegSt4: store_d[st_idx] = in_q.write_data;
          RegIcr: begin
            if (in_q.write_data[IcrSetClrBit]) begin
              flags_d = flags_q & ~(in_q.write_data[FlagWidth-1:0] & FlagMask) & FlagMask;
              irq_d   = 1'b0;
            end else begin
              flags_d = (flags_q | (in_q.write_data[FlagWidth-1:0] & FlagMask)) & FlagMask;
            end
          end
          RegCra:  ta_d = timer_ctl(ta_q, in_q.write_data);
          RegCrb:  tb_d = timer_ctl(tb_q, in_q.write_data);
          default: ;
        endcase
      end
      default: ;
    endcase

    out_d.irq = irq_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_kbd_q <= 1'b1;
      ta_en_q    <= 1'b0;
    end else if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        CfgUnitIsKeyboard: unit_kbd_q <= cfg_i.data;
        CfgTimerAEnable:   ta_en_q    <= cfg_i.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_q.cmd        <= in_i.cmd;
      in_q.reg_addr   <= in_i.reg_addr;
      in_q.write_data <= in_i.write_data;
      in_q.port_a_in  <= in_i.port_a_in;
      in_q.port_b_in  <= in_i.port_b_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ta_q    <= '0;
      tb_q    <= '0;
      flags_q <= '0;
      irq_q   <= 1'b0;
      for (int i = 0; i < StoreDepth; i++) begin
        store_q[i] <= '0;
      end
    end else if (advance) begin
      ta_q    <= ta_d;
      tb_q    <= tb_d;
      flags_q <= flags_d;
      irq_q   <= irq_d;
      store_q <= store_d;
    end
  end

endmodule
